### rtl/core/vcmu_pkg.sv
// ---------------------------------------------------------------------------
// Vector clock message update: shared types and constants
// Field widths of the channels and the sequencer states of the core.
// ---------------------------------------------------------------------------
`default_nettype none

package vcmu_pkg;

	localparam int ID_W  = 5;
	localparam int VAL_W = 32;

	typedef logic [ID_W-1:0]  node_id_t;
	typedef logic [VAL_W-1:0] clock_val_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RUN,
		ST_RCV
	} vcmu_state_t;

endpackage

`default_nettype wire

### rtl/core/vcmu_msg_if.sv
// ---------------------------------------------------------------------------
// Vector clock message update: message channel
// One item names the sender and the receiver of a message.
// ---------------------------------------------------------------------------
`default_nettype none

interface vcmu_msg_if
	import vcmu_pkg::*;
;
	logic     valid;
	logic     ready;
	node_id_t sender_id;
	node_id_t receiver_id;

	modport source (output valid, output sender_id, output receiver_id, input ready);
	modport sink (input valid, input sender_id, input receiver_id, output ready);
endinterface

`default_nettype wire

### rtl/core/vcmu_upd_if.sv
// ---------------------------------------------------------------------------
// Vector clock message update: update channel
// One item carries one entry of the sender's updated vector.
// ---------------------------------------------------------------------------
`default_nettype none

interface vcmu_upd_if
	import vcmu_pkg::*;
;
	logic       valid;
	logic       ready;
	node_id_t   entry_index;
	clock_val_t clock_value;
	logic       last;

	modport source (output valid, output entry_index, output clock_value, output last,
		input ready);
	modport sink (input valid, input entry_index, input clock_value, input last,
		output ready);
endinterface

`default_nettype wire

### rtl/core/vector_clock_message_update_core.sv
// ---------------------------------------------------------------------------
// Vector clock message update core
// Keeps one vector clock per node in a single table memory, applies a
// message event to the sender and receiver rows and streams out the
// sender's merged vector.
// ---------------------------------------------------------------------------
//  channel | dir | payload                               | item
//  msg     | in  | sender_id, receiver_id                | one message event
//  upd     | out | entry_index, clock_value, last        | one vector entry
//
// An item is handled in steps: the core takes it, reads each entry through
// the table memory, whose single write port also takes the merged entry,
// then stores the receiver's own counter unless the receiver is the sender.
// NODE_COUNT update items follow each message.
// After reset all NODE_COUNT*NODE_COUNT table entries are cleared one entry a
// cycle, while msg is held not ready.
// A stall on upd holds the read stage; no entry is lost or read twice.
// ---------------------------------------------------------------------------
`default_nettype none

module vector_clock_message_update_core
	import vcmu_pkg::*;
#(
	parameter int NODE_COUNT    = 24,
	parameter int COUNTER_WIDTH = 32
) (
	input  wire        clk,
	input  wire        arst_n,
	vcmu_msg_if.sink   msg,
	vcmu_upd_if.source upd
);

	localparam int NODE_W = $clog2(NODE_COUNT);
	localparam int DEPTH  = NODE_COUNT * NODE_COUNT;
	localparam int ADDR_W = $clog2(DEPTH);

	localparam logic [NODE_W-1:0]        LAST_IDX = NODE_W'(NODE_COUNT - 1);
	localparam logic [ADDR_W-1:0]        LAST_ADR = ADDR_W'(DEPTH - 1);
	localparam logic [COUNTER_WIDTH-1:0] CTR_MAX  = {COUNTER_WIDTH{1'b1}};

	typedef logic [COUNTER_WIDTH-1:0] ctr_t;

	logic [COUNTER_WIDTH-1:0] clock_mem [DEPTH];

	vcmu_state_t state_q, state_d;

	logic [ADDR_W-1:0] clr_q;
	logic [NODE_W-1:0] snd_node_q, rcv_node_q;
	logic [ADDR_W-1:0] snd_base_q, rcv_base_q;
	logic              same_q;
	logic [NODE_W-1:0] rd_idx_q;
	logic              rd_done_q;
	ctr_t              rcv_val_q;

	logic              valid_s1;
	logic [NODE_W-1:0] idx_s1;
	ctr_t              snd_s1, rcv_s1;

	logic              out_valid_q;
	node_id_t          out_idx_q;
	clock_val_t        out_val_q;
	logic              out_last_q;

	logic              accept, out_free, drain, issue;
	logic [NODE_W-1:0] snd_node, rcv_node;
	logic [ADDR_W-1:0] rd_snd_addr, rd_rcv_addr;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	ctr_t              wr_data;
	logic [1:0]        inc_snd;
	logic              inc_rcv;
	logic [COUNTER_WIDTH:0] sum_snd, sum_rcv;
	ctr_t              snd_new, rcv_new, merged;
	logic [63:0]       merged_ext;

	// Ids beyond the node range stand for node 0.
	assign snd_node = (32'(msg.sender_id) < NODE_COUNT) ? NODE_W'(msg.sender_id) : '0;
	assign rcv_node = (32'(msg.receiver_id) < NODE_COUNT) ? NODE_W'(msg.receiver_id) : '0;

	assign msg.ready = (state_q == ST_IDLE);
	assign accept    = msg.valid && msg.ready;

	assign out_free = !out_valid_q || upd.ready;
	assign drain    = valid_s1 && out_free;
	assign issue    = (state_q == ST_RUN) && !rd_done_q && (!valid_s1 || out_free);

	assign rd_snd_addr = snd_base_q + ADDR_W'(rd_idx_q);
	assign rd_rcv_addr = rcv_base_q + ADDR_W'(rd_idx_q);

	// When sender and receiver coincide both increments land on the same counter.
	always_comb begin
		inc_snd = 2'd0;
		if (idx_s1 == snd_node_q) begin
			inc_snd = same_q ? 2'd2 : 2'd1;
		end
		inc_rcv = (idx_s1 == rcv_node_q);
		sum_snd = {1'b0, snd_s1} + (COUNTER_WIDTH + 1)'(inc_snd);
		sum_rcv = {1'b0, rcv_s1} + (COUNTER_WIDTH + 1)'(inc_rcv);
		snd_new = sum_snd[COUNTER_WIDTH] ? CTR_MAX : sum_snd[COUNTER_WIDTH-1:0];
		rcv_new = sum_rcv[COUNTER_WIDTH] ? CTR_MAX : sum_rcv[COUNTER_WIDTH-1:0];
		merged  = (rcv_new > snd_new) ? rcv_new : snd_new;
		merged_ext = 64'(merged);
	end

	always_comb begin
		state_d = state_q;
		wr_en   = 1'b0;
		wr_addr = snd_base_q + ADDR_W'(idx_s1);
		wr_data = merged;
		case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = '0;
				if (clr_q == LAST_ADR) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				wr_en = drain;
				if (drain && idx_s1 == LAST_IDX) begin
					state_d = ST_RCV;
				end
			end
			ST_RCV: begin
				wr_en   = !same_q;
				wr_addr = rcv_base_q + ADDR_W'(rcv_node_q);
				wr_data = rcv_val_q;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			rd_idx_q    <= '0;
			rd_done_q   <= 1'b0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (accept) begin
				rd_idx_q  <= '0;
				rd_done_q <= 1'b0;
			end else if (issue) begin
				rd_idx_q  <= rd_idx_q + 1'b1;
				rd_done_q <= (rd_idx_q == LAST_IDX);
			end
			if (issue) begin
				valid_s1 <= 1'b1;
			end else if (drain) begin
				valid_s1 <= 1'b0;
			end
			if (drain) begin
				out_valid_q <= 1'b1;
			end else if (upd.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			snd_node_q <= snd_node;
			rcv_node_q <= rcv_node;
			snd_base_q <= ADDR_W'(snd_node) * ADDR_W'(NODE_COUNT);
			rcv_base_q <= ADDR_W'(rcv_node) * ADDR_W'(NODE_COUNT);
			same_q     <= (snd_node == rcv_node);
		end
		if (issue) begin
			idx_s1 <= rd_idx_q;
		end
		if (drain) begin
			out_idx_q  <= ID_W'(idx_s1);
			out_val_q  <= merged_ext[VAL_W-1:0];
			out_last_q <= (idx_s1 == LAST_IDX);
			if (idx_s1 == rcv_node_q) begin
				rcv_val_q <= rcv_new;
			end
		end
	end

	// Table memory: one write port, two registered read ports.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			clock_mem[wr_addr] <= wr_data;
		end
		if (issue) begin
			snd_s1 <= clock_mem[rd_snd_addr];
			rcv_s1 <= clock_mem[rd_rcv_addr];
		end
	end

	assign upd.valid       = out_valid_q;
	assign upd.entry_index = out_idx_q;
	assign upd.clock_value = out_val_q;
	assign upd.last        = out_last_q;

`ifndef SYNTHESIS
	// A write-back never hits an entry that is being read in the same cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(issue && wr_en) |-> (wr_addr != rd_snd_addr && wr_addr != rd_rcv_addr))
		else $error("table write collides with a read");

	// A new message is only taken once the read stage has emptied.
	assert property (@(posedge clk) disable iff (!arst_n)
		msg.ready |-> !valid_s1)
		else $error("message taken while entries are still in flight");

	// The entry with the top index is marked last and the receiver store follows.
	assert property (@(posedge clk) disable iff (!arst_n)
		(drain && idx_s1 == LAST_IDX) |=> (out_last_q && state_q == ST_RCV))
		else $error("last entry not marked or receiver store skipped");

	// The receiver's own counter is stored only when it differs from the sender.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RCV && same_q) |-> !wr_en)
		else $error("receiver store issued for a self message");
`endif

endmodule

`default_nettype wire
